@@ rtl/core/aifs_pkg.sv @@
// Shared types, codes and the character decoder for the integer field scanner.
`timescale 1ns / 1ps

package aifs_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_BASE   = 2'd1,
    PH_PREFIX = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BASE_OCT = 2'd0,
    BASE_DEC = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  typedef enum logic [1:0] {
    MODE_AUTO = 2'd0,
    MODE_DEC  = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_OCT  = 2'd3
  } mode_t;

  localparam logic [1:0] REG_BASE_MODE   = 2'd0;
  localparam logic [1:0] REG_ALLOW_SIGN  = 2'd1;
  localparam logic [1:0] REG_FIELD_WIDTH = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // Control part of the scanner state; the wide fields travel separately.
  typedef struct packed {
    phase_t phase;
    base_t  base;
    logic   neg;
  } ctrl_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // Value of a character as a digit of the given base, with ok low if it is none.
  function automatic digit_t decode_digit(input logic [7:0] c, input base_t b);
    digit_t     d;
    logic [7:0] raw;
    logic       any;
    raw = 8'd0;
    any = 1'b0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      raw = c - CH_ZERO;
      any = 1'b1;
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      raw = c - CH_LOW_A + 8'd10;
      any = 1'b1;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      raw = c - CH_UP_A + 8'd10;
      any = 1'b1;
    end
    d.val = raw[3:0];
    unique case (b)
      BASE_OCT: d.ok = any && (raw < 8'd8);
      BASE_DEC: d.ok = any && (raw < 8'd10);
      BASE_HEX: d.ok = any;
      default:  d.ok = 1'b0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/core/aifs_char_if.sv @@
// Input channel carrying one text character per word.
`timescale 1ns / 1ps

interface aifs_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

@@ rtl/core/aifs_result_if.sv @@
// Output channel carrying one converted field per word.
`timescale 1ns / 1ps

interface aifs_result_if #(
  parameter int VALUE_BITS = 32,
  parameter int WIDTH_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [WIDTH_BITS-1:0] chars_used;
  logic                  last_taken;

  modport source (output valid, output value, output chars_used, output last_taken,
                  input ready);
  modport sink   (input valid, input value, input chars_used, input last_taken,
                  output ready);
endinterface

@@ rtl/core/aifs_step.sv @@
// Combinational next-state logic of the scanner for one character.
`timescale 1ns / 1ps

module aifs_step #(
  parameter int VALUE_BITS = 32,
  parameter int WIDTH_BITS = 8
) (
  input  logic [7:0]             char_code,
  input  aifs_pkg::ctrl_t        ctrl,
  input  logic [VALUE_BITS-1:0]  acc,
  input  logic [WIDTH_BITS-1:0]  used,
  input  logic [WIDTH_BITS-1:0]  wleft,
  input  aifs_pkg::mode_t        base_mode,
  input  logic                   allow_sign,
  input  logic [WIDTH_BITS-1:0]  field_width,
  output aifs_pkg::ctrl_t        ctrl_next,
  output logic [VALUE_BITS-1:0]  acc_next,
  output logic [WIDTH_BITS-1:0]  used_next,
  output logic [WIDTH_BITS-1:0]  wleft_next,
  output logic                   emit,
  output logic [VALUE_BITS-1:0]  emit_value,
  output logic                   emit_taken
);
  import aifs_pkg::*;

  always_comb begin
    phase_t                ph;
    phase_t                take_ph;
    base_t                 b;
    logic                  neg;
    logic [VALUE_BITS-1:0] a;
    logic [VALUE_BITS-1:0] scaled;
    logic [WIDTH_BITS-1:0] u;
    logic [WIDTH_BITS-1:0] w;
    logic                  take;
    logic                  digit_path;
    logic                  reject;
    logic                  ran_out;
    digit_t                d;

    take       = 1'b0;
    take_ph    = PH_DIGITS;
    digit_path = 1'b0;
    reject     = 1'b0;
    ran_out    = 1'b0;
    scaled     = '0;

    if (ctrl.phase == PH_IDLE) begin
      ph  = PH_BASE;
      b   = BASE_DEC;
      neg = 1'b0;
      a   = '0;
      u   = '0;
      w   = field_width;
    end else begin
      ph  = ctrl.phase;
      b   = ctrl.base;
      neg = ctrl.neg;
      a   = acc;
      u   = used;
      w   = wleft;
    end

    if (ctrl.phase == PH_IDLE && allow_sign && char_code == CH_MINUS) begin
      neg     = 1'b1;
      take    = 1'b1;
      take_ph = PH_BASE;
    end else begin
      unique case (ph)
        PH_BASE: begin
          if (base_mode == MODE_AUTO && char_code == CH_ZERO) begin
            b       = BASE_OCT;
            take    = 1'b1;
            take_ph = PH_PREFIX;
          end else begin
            unique case (base_mode)
              MODE_HEX: b = BASE_HEX;
              MODE_OCT: b = BASE_OCT;
              default:  b = BASE_DEC;
            endcase
            digit_path = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (char_code == CH_LOW_X || char_code == CH_UP_X) begin
            b       = BASE_HEX;
            take    = 1'b1;
            take_ph = PH_DIGITS;
          end else begin
            b          = BASE_OCT;
            digit_path = 1'b1;
          end
        end
        default: digit_path = 1'b1;
      endcase
    end

    d = decode_digit(char_code, b);
    if (digit_path) begin
      if (d.ok) begin
        unique case (b)
          BASE_OCT: scaled = a << 3;
          BASE_HEX: scaled = a << 4;
          default:  scaled = (a << 3) + (a << 1);
        endcase
        a       = scaled + VALUE_BITS'(d.val);
        take    = 1'b1;
        take_ph = PH_DIGITS;
      end else begin
        reject = 1'b1;
      end
    end

    if (take) begin
      if (u != '1) u = u + 1'b1;
      if (w != '0) begin
        w       = w - 1'b1;
        ran_out = (w == '0);
      end
    end

    emit       = reject || ran_out;
    emit_taken = ran_out;
    emit_value = neg ? (VALUE_BITS'(0) - a) : a;

    ctrl_next.phase = emit ? PH_IDLE : (take ? take_ph : ph);
    ctrl_next.base  = b;
    ctrl_next.neg   = neg;
    acc_next        = a;
    used_next       = u;
    wleft_next      = w;
  end

endmodule

@@ rtl/core/ascii_integer_field_scanner_top.sv @@
// Top level of the ASCII integer field scanner.
`timescale 1ns / 1ps

// Converts one integer field from a stream of text characters, one character per
// word on char_in, and delivers the value, the number of characters consumed and
// whether the ending character was consumed as one word on result_out. A new
// character can be accepted in every clock cycle while result words are taken as
// they come. The character ending the field is first held in the input register,
// where the combinational shift-and-add step works on it, and the result register
// is loaded from that step. While a result word waits for result_out.ready the
// input register holds, and char_in.ready stays low once that register is full.
// The character that ends a field by not being a digit is not part of it and
// must be sent again as the start of the next field if it belongs there.
// Configuration must be written through cfg_we, cfg_index and cfg_data only while
// no field is in progress; the block itself does not enforce this.
module ascii_integer_field_scanner_top #(
  parameter int VALUE_BITS = 32,
  parameter int WIDTH_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [WIDTH_BITS-1:0] cfg_data,
  aifs_char_if.sink             char_in,
  aifs_result_if.source         result_out
);
  import aifs_pkg::*;

  mode_t                 base_mode;
  logic                  allow_sign;
  logic [WIDTH_BITS-1:0] field_width;

  logic                  in_valid;
  logic [7:0]            in_char;

  ctrl_t                 ctrl;
  ctrl_t                 ctrl_next;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] acc_next;
  logic [WIDTH_BITS-1:0] used;
  logic [WIDTH_BITS-1:0] used_next;
  logic [WIDTH_BITS-1:0] wleft;
  logic [WIDTH_BITS-1:0] wleft_next;
  logic                  emit;
  logic [VALUE_BITS-1:0] emit_value;
  logic                  emit_taken;

  logic                  out_valid;
  logic [VALUE_BITS-1:0] out_value;
  logic [WIDTH_BITS-1:0] out_used;
  logic                  out_taken;
  logic                  advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode   <= MODE_AUTO;
      allow_sign  <= 1'b1;
      field_width <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_MODE:   base_mode   <= mode_t'(cfg_data[1:0]);
        REG_ALLOW_SIGN:  allow_sign  <= cfg_data[0];
        REG_FIELD_WIDTH: field_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // The registered character is processed once the result register can take
  // whatever it may produce.
  assign advance       = in_valid && (!out_valid || result_out.ready);
  assign char_in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_in.ready) begin
      in_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready && char_in.valid) begin
      in_char <= char_in.char_code;
    end
  end

  aifs_step #(
    .VALUE_BITS(VALUE_BITS),
    .WIDTH_BITS(WIDTH_BITS)
  ) u_step (
    .char_code  (in_char),
    .ctrl       (ctrl),
    .acc        (acc),
    .used       (used),
    .wleft      (wleft),
    .base_mode  (base_mode),
    .allow_sign (allow_sign),
    .field_width(field_width),
    .ctrl_next  (ctrl_next),
    .acc_next   (acc_next),
    .used_next  (used_next),
    .wleft_next (wleft_next),
    .emit       (emit),
    .emit_value (emit_value),
    .emit_taken (emit_taken)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl  <= '{phase: PH_IDLE, base: BASE_OCT, neg: 1'b0};
      acc   <= '0;
      used  <= '0;
      wleft <= '0;
    end else if (advance) begin
      ctrl  <= ctrl_next;
      acc   <= acc_next;
      used  <= used_next;
      wleft <= wleft_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_value <= emit_value;
      out_used  <= used_next;
      out_taken <= emit_taken;
    end
  end

  assign result_out.valid      = out_valid;
  assign result_out.value      = out_value;
  assign result_out.chars_used = out_used;
  assign result_out.last_taken = out_taken;

endmodule

@@ rtl/core/aifs_checker.sv @@
// Port-level checks for the integer field scanner and their attachment to it.
`timescale 1ns / 1ps

module aifs_checker #(
  parameter int VALUE_BITS = 32,
  parameter int WIDTH_BITS = 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VALUE_BITS-1:0] out_value,
  input logic [WIDTH_BITS-1:0] out_used,
  input logic                  out_taken
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_used)
                                && $stable(out_taken))
    else $error("stalled result word changed");

  // A consumed ending character always counts towards the field.
  a_taken_counts: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_taken |-> out_used != '0)
    else $error("consumed ending character not counted");

  // A field that consumed nothing can only be zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_taken && out_used == '0 |-> out_value == '0)
    else $error("empty field produced a non-zero value");

endmodule

bind ascii_integer_field_scanner_top aifs_checker #(
  .VALUE_BITS(VALUE_BITS),
  .WIDTH_BITS(WIDTH_BITS)
) u_aifs_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(result_out.valid),
  .out_ready(result_out.ready),
  .out_value(result_out.value),
  .out_used (result_out.chars_used),
  .out_taken(result_out.last_taken)
);
